// ===== hdl/bpa_pkg.sv =====
//------------------------------------------------------------------------------
// bpa_pkg
// Shared widths, operation codes and defaults for the bitmap page allocator.
//------------------------------------------------------------------------------
`default_nettype none

package bpa_pkg;

  localparam int DEF_MAX_PAGES = 4096;
  localparam int DEF_WORD_BITS = 32;

  localparam int OP_W       = 2;
  localparam int FIRST_W    = 12;
  localparam int CNT_W      = 13;
  localparam int PG_W       = 14;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;

  typedef logic [OP_W-1:0] op_t;

  localparam op_t OP_TAKE = 2'd0;
  localparam op_t OP_FREE = 2'd1;
  localparam op_t OP_FIND = 2'd2;

endpackage

`default_nettype wire

// ===== hdl/bitmap_page_allocator.sv =====
//------------------------------------------------------------------------------
// bitmap_page_allocator
// One bit per page in a word-wide bitmap memory plus a taken-page count;
// marks runs taken or free and finds the lowest free run of a given length.
//------------------------------------------------------------------------------
// channel | dir | tdata (low bit up)                    | tuser
// in_     | in  | first_page[11:0], page_count[24:12]   | op[1:0]
// out_    | out | start_page[11:0], free_pages[24:12]   | found[0]
// cfg_    | in  | cfg_wdata = page_total[12:0], cfg_we  | -
//
// Mark reads, updates and writes back each bitmap word of the run in turn;
// find reads the words in order until a fitting run or the last word.
// A mark does one read-modify-write of a bitmap word per cycle on the
// bitmap memory. After reset a clearing pass writes zero to every
// bitmap word before in_tready rises. A stalled result waits in the
// output register while the next transfer is accepted.
// WORD_BITS must be a power of two.
//------------------------------------------------------------------------------
`default_nettype none

module bitmap_page_allocator #(
  parameter int MAX_PAGES = bpa_pkg::DEF_MAX_PAGES,
  parameter int WORD_BITS = bpa_pkg::DEF_WORD_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [bpa_pkg::IN_DATA_W-1:0]   in_tdata,   // first_page, page_count
  input  logic [bpa_pkg::OP_W-1:0]        in_tuser,   // op
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [bpa_pkg::OUT_DATA_W-1:0]  out_tdata,  // start_page, free_pages
  output logic [0:0]                      out_tuser,  // found
  input  logic                            cfg_we,
  input  logic [bpa_pkg::CNT_W-1:0]       cfg_wdata
);

  import bpa_pkg::*;

  localparam int WORD_COUNT = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int WI_W       = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int DW         = $clog2(WORD_BITS + 1);

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [WI_W-1:0]      widx_t;

  localparam word_t ONES = '1;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_SETUP, ST_RUN, ST_DRAIN, ST_RESP
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    page_total_r, page_total_nxt;
  logic [CNT_W-1:0]    eff_total;
  op_t                 op_r, op_nxt;
  logic [FIRST_W-1:0]  first_r, first_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    total_r, total_nxt;
  widx_t               w0_r, w0_nxt;
  widx_t               last_w_r, last_w_nxt;
  logic [PG_W-1:0]     endm1_r, endm1_nxt;
  word_t               therm_r, therm_nxt;
  logic                cnt_small_r, cnt_small_nxt;
  widx_t               issue_w_r, issue_w_nxt;
  logic                issue_on_r, issue_on_nxt;
  logic                p_vld_r, p_vld_nxt;
  widx_t               p_w_r, p_w_nxt;
  word_t               rdata_r;
  logic [PG_W-1:0]     carry_r, carry_nxt;
  logic [DW-1:0]       delta_r, delta_nxt;
  logic                delta_v_r, delta_v_nxt;
  logic                delta_take_r, delta_take_nxt;
  logic [CNT_W-1:0]    taken_r, taken_nxt;
  logic                res_found_r, res_found_nxt;
  logic [FIRST_W-1:0]  res_start_r, res_start_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_found_r, out_found_nxt;
  logic [FIRST_W-1:0]  out_start_r, out_start_nxt;
  logic [CNT_W-1:0]    out_free_r, out_free_nxt;
  widx_t               clr_w_r, clr_w_nxt;

  word_t               mem [WORD_COUNT];
  logic                mem_we, mem_re;
  widx_t               mem_wa, mem_ra;
  word_t               mem_wd;

  // setup terms
  logic [PG_W-1:0]     first_ext, cnt_ext, tot_ext, end_raw, end_clip;
  logic                su_go;
  logic [PG_W-1:0]     su_endm1;
  widx_t               su_w0;

  // per-word terms
  logic [PG_W-1:0]     page_base;
  logic                at_first, at_last, is_take;
  logic [BIT_W-1:0]    lo_bit, hi_bit;
  word_t               hi_mask, mark_mask, new_word, chg;
  logic [DW-1:0]       pc;
  word_t               fr, e_vec, p_vec, c_vec, fit;
  logic                cmp_all;
  logic [PG_W-1:0]     thr_u;
  logic [BIT_W-1:0]    hit_b;
  logic [PG_W-1:0]     hit_start, lead;

  assign eff_total = (int'(page_total_r) > MAX_PAGES) ? CNT_W'(MAX_PAGES) : page_total_r;

  // setup: clip the run and find the word range
  always_comb begin
    first_ext = PG_W'(first_r);
    cnt_ext   = PG_W'(cnt_r);
    tot_ext   = PG_W'(total_r);
    end_raw   = first_ext + cnt_ext;
    end_clip  = (end_raw > tot_ext) ? tot_ext : end_raw;
    su_go     = 1'b0;
    su_endm1  = '0;
    su_w0     = '0;
    case (op_r)
      OP_TAKE, OP_FREE: begin
        su_go    = (cnt_r != '0) && (first_ext < tot_ext);
        su_endm1 = end_clip - PG_W'(1);
        su_w0    = widx_t'(first_ext >> BIT_W);
      end
      OP_FIND: begin
        su_go    = (cnt_r != '0) && (total_r != '0);
        su_endm1 = tot_ext - PG_W'(1);
        su_w0    = '0;
      end
      default: su_go = 1'b0;
    endcase
  end

  // per-word mark and search logic
  always_comb begin
    page_base = PG_W'(p_w_r) << BIT_W;
    at_first  = (p_w_r == w0_r);
    at_last   = (p_w_r == last_w_r);
    is_take   = (op_r == OP_TAKE);
    lo_bit    = at_first ? first_r[BIT_W-1:0] : '0;
    hi_bit    = at_last ? endm1_r[BIT_W-1:0] : '1;
    hi_mask   = ONES >> (~hi_bit);
    mark_mask = (ONES << lo_bit) & hi_mask;
    new_word  = is_take ? (rdata_r | mark_mask) : (rdata_r & ~mark_mask);
    chg       = is_take ? (mark_mask & ~rdata_r) : (mark_mask & rdata_r);
    pc        = '0;
    for (int b = 0; b < WORD_BITS; b++) pc = pc + DW'(chg[b]);

    fr = ~rdata_r & (at_last ? hi_mask : ONES);
    for (int b = 0; b < WORD_BITS; b++) begin
      e_vec[b] = cnt_small_r;
      p_vec[b] = 1'b1;
      for (int k = 0; k < WORD_BITS; k++) begin
        if (k <= b) begin
          if (therm_r[k]) e_vec[b] = e_vec[b] & fr[b-k];
          p_vec[b] = p_vec[b] & fr[k];
        end else if (therm_r[k]) begin
          e_vec[b] = 1'b0;
        end
      end
    end
    cmp_all = ({1'b0, carry_r} + (PG_W+1)'(1)) >= {1'b0, cnt_ext};
    thr_u   = cnt_ext - carry_r - PG_W'(1);
    for (int b = 0; b < WORD_BITS; b++) begin
      c_vec[b] = p_vec[b] & (cmp_all | (PG_W'(b) >= thr_u));
    end
    fit   = e_vec | c_vec;
    hit_b = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (fit[b]) hit_b = BIT_W'(b);
    end
    hit_start = page_base + PG_W'(hit_b) + PG_W'(1) - cnt_ext;
    lead = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (!fr[b]) lead = PG_W'(WORD_BITS - 1 - b);
    end
  end

  // next state
  always_comb begin
    state_nxt      = state_r;
    page_total_nxt = cfg_we ? cfg_wdata : page_total_r;
    op_nxt         = op_r;
    first_nxt      = first_r;
    cnt_nxt        = cnt_r;
    total_nxt      = total_r;
    w0_nxt         = w0_r;
    last_w_nxt     = last_w_r;
    endm1_nxt      = endm1_r;
    therm_nxt      = therm_r;
    cnt_small_nxt  = cnt_small_r;
    issue_w_nxt    = issue_w_r;
    issue_on_nxt   = issue_on_r;
    p_w_nxt        = issue_w_r;
    carry_nxt      = carry_r;
    delta_nxt      = pc;
    delta_v_nxt    = 1'b0;
    delta_take_nxt = is_take;
    res_found_nxt  = res_found_r;
    res_start_nxt  = res_start_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_found_nxt  = out_found_r;
    out_start_nxt  = out_start_r;
    out_free_nxt   = out_free_r;
    clr_w_nxt      = clr_w_r;
    taken_nxt      = taken_r;
    in_tready      = 1'b0;
    mem_we         = 1'b0;
    mem_wa         = p_w_r;
    mem_wd         = new_word;
    mem_re         = 1'b0;
    mem_ra         = issue_w_r;

    if (delta_v_r) begin
      taken_nxt = delta_take_r ? (taken_r + CNT_W'(delta_r)) : (taken_r - CNT_W'(delta_r));
    end

    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wa    = clr_w_r;
        mem_wd    = '0;
        clr_w_nxt = clr_w_r + widx_t'(1);
        if (clr_w_r == widx_t'(WORD_COUNT - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          op_nxt    = in_tuser;
          first_nxt = in_tdata[FIRST_W-1:0];
          cnt_nxt   = in_tdata[FIRST_W+CNT_W-1:FIRST_W];
          total_nxt = eff_total;
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        res_found_nxt = 1'b0;
        res_start_nxt = '0;
        w0_nxt        = su_w0;
        last_w_nxt    = widx_t'(su_endm1 >> BIT_W);
        endm1_nxt     = su_endm1;
        for (int k = 0; k < WORD_BITS; k++) therm_nxt[k] = (PG_W'(k) < cnt_ext);
        cnt_small_nxt = (cnt_ext <= PG_W'(WORD_BITS));
        issue_w_nxt   = su_w0;
        issue_on_nxt  = 1'b1;
        carry_nxt     = '0;
        state_nxt     = su_go ? ST_RUN : ST_RESP;
      end
      ST_RUN: begin
        mem_re = issue_on_r;
        if (issue_on_r) begin
          issue_w_nxt  = issue_w_r + widx_t'(1);
          issue_on_nxt = (issue_w_r != last_w_r);
        end
        if (p_vld_r) begin
          if (op_r == OP_FIND) begin
            carry_nxt = p_vec[WORD_BITS-1] ? (carry_r + PG_W'(WORD_BITS)) : lead;
            if (|fit) begin
              res_found_nxt = 1'b1;
              res_start_nxt = hit_start[FIRST_W-1:0];
              state_nxt     = ST_RESP;
            end else if (at_last) begin
              state_nxt = ST_RESP;
            end
          end else begin
            mem_we      = 1'b1;
            delta_v_nxt = 1'b1;
            if (at_last) state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: state_nxt = ST_RESP;
      ST_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_start_nxt = res_start_r;
          out_free_nxt  = (total_r > taken_r) ? (total_r - taken_r) : '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    p_vld_nxt = mem_re;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rdata_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      page_total_r <= CNT_W'(4096);
      clr_w_r      <= '0;
      issue_on_r   <= 1'b0;
      p_vld_r      <= 1'b0;
      delta_v_r    <= 1'b0;
      taken_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      page_total_r <= page_total_nxt;
      clr_w_r      <= clr_w_nxt;
      issue_on_r   <= issue_on_nxt;
      p_vld_r      <= p_vld_nxt;
      delta_v_r    <= delta_v_nxt;
      taken_r      <= taken_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    first_r      <= first_nxt;
    cnt_r        <= cnt_nxt;
    total_r      <= total_nxt;
    w0_r         <= w0_nxt;
    last_w_r     <= last_w_nxt;
    endm1_r      <= endm1_nxt;
    therm_r      <= therm_nxt;
    cnt_small_r  <= cnt_small_nxt;
    issue_w_r    <= issue_w_nxt;
    p_w_r        <= p_w_nxt;
    carry_r      <= carry_nxt;
    delta_r      <= delta_nxt;
    delta_take_r <= delta_take_nxt;
    res_found_r  <= res_found_nxt;
    res_start_r  <= res_start_nxt;
    out_found_r  <= out_found_nxt;
    out_start_r  <= out_start_nxt;
    out_free_r   <= out_free_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - FIRST_W - CNT_W)'(0), out_free_r, out_start_r};
  assign out_tuser  = out_found_r;

  a_rmw_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_wa != mem_ra))
    else $error("bitmap read and write hit the same word");

  a_word_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && p_vld_r) |-> (p_w_r <= last_w_r))
    else $error("processed word past end of range");

  a_delta_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    delta_v_r |-> $past(state_r == ST_RUN))
    else $error("count update outside of a mark run");

  a_taken_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(taken_r) <= MAX_PAGES)
    else $error("taken page count exceeds page capacity");

endmodule

`default_nettype wire
